// ----- sv/thac_pkg.sv -----
// ----------------------------------------------------------------------------
// thac_pkg
// Shared types and constants of the twelve-hour alarm clock core.
// ----------------------------------------------------------------------------
package thac_pkg;

    // Debounce shift history.
    localparam logic [15:0] DEB_FILL    = 16'hE000;
    localparam logic [15:0] DEB_PRESSED = 16'hF000;

    // Encoder transition codes.
    localparam logic [7:0] ENC_MIN_UP   = 8'hFE;
    localparam logic [7:0] ENC_MIN_DOWN = 8'hFD;
    localparam logic [7:0] ENC_MIN_TO   = 8'hFC;
    localparam logic [7:0] ENC_HR_UP    = 8'hFB;
    localparam logic [7:0] ENC_HR_DOWN  = 8'hF7;
    localparam logic [7:0] ENC_HR_TO    = 8'hF3;

    localparam logic [5:0] MINUTE_MAX         = 6'd59;
    localparam logic [3:0] HOUR_MAX           = 4'd12;
    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [9:0] SNOOZE_RESET       = 10'd10;

    localparam int BUTTON_COUNT = 4;

    // Button positions in the raw level vector.
    localparam int BTN_SET_TIME  = 0;
    localparam int BTN_SET_ALARM = 1;
    localparam int BTN_SNOOZE    = 2;
    localparam int BTN_OFF       = 3;

    typedef struct packed {
        logic off;
        logic snooze;
        logic set_alarm;
        logic time_key;
    } press_t;

    typedef struct packed {
        logic       armed;
        logic       ringing;
        logic       snoozing;
        logic       setting_alarm;
        logic       setting_time;
        logic       alarm_is_pm;
        logic [5:0] alarm_minutes;
        logic [3:0] alarm_hours;
        logic       is_pm;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [3:0] hours;
    } result_t;

endpackage

// ----- sv/thac_debounce.sv -----
// ----------------------------------------------------------------------------
// thac_debounce
// Shift-history debounce of the four active-low buttons, one press per push.
// ----------------------------------------------------------------------------
module thac_debounce
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [thac_pkg::BUTTON_COUNT-1:0]   levels,
    output thac_pkg::press_t                    press
);

    logic [15:0] history_reg  [thac_pkg::BUTTON_COUNT];
    logic [15:0] history_next [thac_pkg::BUTTON_COUNT];
    logic [thac_pkg::BUTTON_COUNT-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < thac_pkg::BUTTON_COUNT; i++)
        begin
            history_next[i] = {history_reg[i][14:0], levels[i]} | thac_pkg::DEB_FILL;
            hit[i]          = (history_next[i] == thac_pkg::DEB_PRESSED);
        end
    end

    assign press.time_key  = hit[thac_pkg::BTN_SET_TIME];
    assign press.set_alarm = hit[thac_pkg::BTN_SET_ALARM];
    assign press.snooze    = hit[thac_pkg::BTN_SNOOZE];
    assign press.off       = hit[thac_pkg::BTN_OFF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < thac_pkg::BUTTON_COUNT; i++)
            begin
                history_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < thac_pkg::BUTTON_COUNT; i++)
            begin
                history_reg[i] <= history_next[i];
            end
        end
    end

endmodule

// ----- sv/thac_timekeep.sv -----
// ----------------------------------------------------------------------------
// thac_timekeep
// Time, alarm, mode and snooze state with the per-word update logic.
// ----------------------------------------------------------------------------
module thac_timekeep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                tick,
    input  logic [7:0]          encoder,
    input  thac_pkg::press_t    press,
    input  logic [9:0]          snooze_seconds,
    output thac_pkg::result_t   result
);

    function automatic logic [5:0] minute_step(input logic [5:0] m, input logic up);
        logic [5:0] r;
        if (up)
        begin
            r = (m >= thac_pkg::MINUTE_MAX) ? 6'd0 : m + 6'd1;
        end
        else
        begin
            r = (m == 6'd0 || m > thac_pkg::MINUTE_MAX) ? thac_pkg::MINUTE_MAX : m - 6'd1;
        end
        return r;
    endfunction

    // Returns {pm, hour}; the PM flag flips on the wrap between 12 and 1.
    function automatic logic [4:0] hour_step(input logic [3:0] h, input logic pm,
                                             input logic up);
        logic [4:0] r;
        if (up)
        begin
            r = (h >= thac_pkg::HOUR_MAX) ? {~pm, 4'd1} : {pm, h + 4'd1};
        end
        else
        begin
            r = (h <= 4'd1 || h > thac_pkg::HOUR_MAX) ? {~pm, thac_pkg::HOUR_MAX}
                                                       : {pm, h - 4'd1};
        end
        return r;
    endfunction

    logic [7:0] prev_enc_reg;
    logic [5:0] sec_reg;
    logic [5:0] min_reg;
    logic [3:0] hour_reg;
    logic       pm_reg;
    logic [3:0] al_hour_reg;
    logic [5:0] al_min_reg;
    logic       al_pm_reg;
    logic       mode_time_reg;
    logic       mode_alarm_reg;
    logic       mode_snooze_reg;
    logic [9:0] elapsed_reg;
    logic       ring_reg;

    logic [5:0] sec_next;
    logic [5:0] min_next;
    logic [3:0] hour_next;
    logic       pm_next;
    logic [3:0] al_hour_next;
    logic [5:0] al_min_next;
    logic       al_pm_next;
    logic       mode_time_next;
    logic       mode_alarm_next;
    logic       mode_snooze_next;
    logic [9:0] elapsed_next;
    logic       ring_next;

    logic [5:0] sec_ticked;
    logic [9:0] elapsed_ticked;
    logic       early_match;
    logic       min_up;
    logic       min_dn;
    logic       hr_up;
    logic       hr_dn;
    logic [5:0] min_e;
    logic [4:0] hr_e;
    logic [5:0] min_roll;
    logic [4:0] hr_roll;
    logic       late_match;

    always_comb
    begin
        sec_ticked     = tick ? sec_reg + 6'd1 : sec_reg;
        elapsed_ticked = (tick && mode_snooze_reg) ? elapsed_reg + 10'd1 : elapsed_reg;

        // Leaving set-alarm mode checks the alarm against the time before the encoder.
        early_match = (al_hour_reg == hour_reg) && (al_min_reg == min_reg) &&
                      (al_pm_reg == pm_reg) && (sec_ticked == 6'd0);

        mode_time_next   = mode_time_reg ^ press.time_key;
        mode_alarm_next  = press.set_alarm ? ~mode_alarm_reg : mode_alarm_reg;
        mode_snooze_next = mode_snooze_reg ^ press.snooze;
        ring_next        = ring_reg | (press.set_alarm & mode_alarm_reg & early_match);

        min_up = (prev_enc_reg == thac_pkg::ENC_MIN_UP)   && (encoder == thac_pkg::ENC_MIN_TO);
        min_dn = (prev_enc_reg == thac_pkg::ENC_MIN_DOWN) && (encoder == thac_pkg::ENC_MIN_TO);
        hr_up  = (prev_enc_reg == thac_pkg::ENC_HR_UP)    && (encoder == thac_pkg::ENC_HR_TO);
        hr_dn  = (prev_enc_reg == thac_pkg::ENC_HR_DOWN)  && (encoder == thac_pkg::ENC_HR_TO);

        min_e = min_reg;
        hr_e  = {pm_reg, hour_reg};
        if (mode_time_next && (min_up || min_dn))
        begin
            min_e = minute_step(min_reg, min_up);
        end
        if (mode_time_next && (hr_up || hr_dn))
        begin
            hr_e = hour_step(hour_reg, pm_reg, hr_up);
        end

        al_min_next  = al_min_reg;
        al_hour_next = al_hour_reg;
        al_pm_next   = al_pm_reg;
        if (mode_alarm_next && (min_up || min_dn))
        begin
            al_min_next = minute_step(al_min_reg, min_up);
        end
        if (mode_alarm_next && (hr_up || hr_dn))
        begin
            {al_pm_next, al_hour_next} = hour_step(al_hour_reg, al_pm_reg, hr_up);
        end

        // Seconds and minutes roll over after the encoder adjustment.
        if (sec_ticked >= thac_pkg::SECONDS_PER_MINUTE)
        begin
            sec_next = 6'd0;
            min_roll = min_e + 6'd1;
        end
        else
        begin
            sec_next = sec_ticked;
            min_roll = min_e;
        end
        hr_roll = hour_step(hr_e[3:0], hr_e[4], 1'b1);
        if (min_roll > thac_pkg::MINUTE_MAX)
        begin
            min_next              = 6'd0;
            {pm_next, hour_next}  = hr_roll;
        end
        else
        begin
            min_next              = min_roll;
            {pm_next, hour_next}  = hr_e;
        end

        late_match = (al_hour_next == hour_next) && (al_min_next == min_next) &&
                     (al_pm_next == pm_next) && (sec_next == 6'd0);
        if (late_match)
        begin
            ring_next = 1'b1;
        end
        if (mode_snooze_next)
        begin
            ring_next = 1'b0;
        end
        elapsed_next = elapsed_ticked;
        if (elapsed_ticked == snooze_seconds)
        begin
            mode_snooze_next = 1'b0;
            ring_next        = 1'b1;
            elapsed_next     = 10'd0;
        end
        if (press.off)
        begin
            ring_next = 1'b0;
        end
    end

    always_comb
    begin
        result.hours         = hour_next;
        result.minutes       = min_next;
        result.seconds       = sec_next;
        result.is_pm         = pm_next;
        result.alarm_hours   = al_hour_next;
        result.alarm_minutes = al_min_next;
        result.alarm_is_pm   = al_pm_next;
        result.setting_time  = mode_time_next;
        result.setting_alarm = mode_alarm_next;
        result.snoozing      = mode_snooze_next;
        result.ringing       = ring_next;
        result.armed         = (al_hour_next != 4'd0) || (al_min_next != 6'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_enc_reg    <= '0;
            sec_reg         <= '0;
            min_reg         <= '0;
            hour_reg        <= thac_pkg::HOUR_MAX;
            pm_reg          <= 1'b0;
            al_hour_reg     <= '0;
            al_min_reg      <= '0;
            al_pm_reg       <= 1'b0;
            mode_time_reg   <= 1'b0;
            mode_alarm_reg  <= 1'b0;
            mode_snooze_reg <= 1'b0;
            elapsed_reg     <= '0;
            ring_reg        <= 1'b0;
        end
        else if (step)
        begin
            prev_enc_reg    <= encoder;
            sec_reg         <= sec_next;
            min_reg         <= min_next;
            hour_reg        <= hour_next;
            pm_reg          <= pm_next;
            al_hour_reg     <= al_hour_next;
            al_min_reg      <= al_min_next;
            al_pm_reg       <= al_pm_next;
            mode_time_reg   <= mode_time_next;
            mode_alarm_reg  <= mode_alarm_next;
            mode_snooze_reg <= mode_snooze_next;
            elapsed_reg     <= elapsed_next;
            ring_reg        <= ring_next;
        end
    end

endmodule

// ----- sv/twelve_hour_alarm_clock_core_unit.sv -----
// ----------------------------------------------------------------------------
// twelve_hour_alarm_clock_core_unit
// Twelve-hour alarm clock core: one main-loop pass per input word.
//
// Channel   Direction  Signals                               Content
// s_axis    in         tvalid tready tdata[15:0]             one loop pass
// m_axis    out        tvalid tready tdata[39:0]             clock status
// cfg       in         valid ready data[9:0]                 snooze length
//
// A word moves from the input register through the update logic into the result
// register; one word is taken per clock at full rate while m_axis is not stalled.
// Rate is set by the single update stage that owns the clock state.
// Reset clears the handshake and sets time to 12:00:00 AM, snooze length 10.
// A stalled output holds its word while the input register still takes one more.
// ----------------------------------------------------------------------------
module twelve_hour_alarm_clock_core_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] second_tick, [8:1] encoder_bits, [12:9] button_levels, [15:13] zero
    input  logic [15:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] hours, [9:4] minutes, [15:10] seconds, [16] is_pm,
    // [20:17] alarm_hours, [26:21] alarm_minutes, [27] alarm_is_pm,
    // [28] setting_time, [29] setting_alarm, [30] snoozing, [31] ringing,
    // [32] armed, [39:33] zero
    output logic [39:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    logic              in_valid_reg;
    logic              tick_reg;
    logic [7:0]        enc_reg;
    logic [3:0]        levels_reg;
    logic              out_valid_reg;
    thac_pkg::result_t out_reg;
    logic [9:0]        snooze_reg;

    logic              advance;
    thac_pkg::press_t  press;
    thac_pkg::result_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    thac_debounce u_debounce
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .levels (levels_reg),
        .press  (press)
    );

    thac_timekeep u_timekeep
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .tick           (tick_reg),
        .encoder        (enc_reg),
        .press          (press),
        .snooze_seconds (snooze_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snooze_reg <= thac_pkg::SNOOZE_RESET;
        end
        else if (cfg_valid)
        begin
            snooze_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            tick_reg   <= s_axis_tdata[0];
            enc_reg    <= s_axis_tdata[8:1];
            levels_reg <= s_axis_tdata[12:9];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.armed, out_reg.ringing, out_reg.snoozing,
                            out_reg.setting_alarm, out_reg.setting_time,
                            out_reg.alarm_is_pm, out_reg.alarm_minutes,
                            out_reg.alarm_hours, out_reg.is_pm, out_reg.seconds,
                            out_reg.minutes, out_reg.hours};

endmodule
